FILE: hw/rtl/positional_list_engine_macros.svh
// ----------------------------------------------------------------------------
// positional_list_engine_macros
// Assertion helpers for the list engine top level.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// property checked on every clock edge outside reset
`define PLE_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// same-cycle implication
`define PLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  `PLE_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

FILE: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Types and codes shared by the list engine top level and its cells.
// ----------------------------------------------------------------------------
package ple_pkg;

  // index width used in cell commands, covers the largest capacity
  localparam int IDX_W = 13;

  // operation codes on the input beat
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_SEARCH = 3'd2;
  localparam logic [2:0] MODE_REVERSE = 3'd3;
  localparam logic [2:0] MODE_SORTED = 3'd4;

  // status codes on the result beat
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_BADPOS = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS,
    OP_REM,
    OP_ROT,
    OP_LOAD,
    OP_SCAN
  } cell_op_e;

  typedef enum logic [1:0] {
    MT_IDX,
    MT_VAL,
    MT_SORT
  } match_e;

  typedef struct packed {
    cell_op_e           op;
    match_e             mt;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   cnt;
    logic signed [31:0] val;
  } cell_cmd_t;

  typedef struct packed {
    logic        hit;
    logic        aux;
    logic [31:0] tag;
  } lane_t;

endpackage

FILE: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Packed list of signed 32-bit values with insert, remove, search, reverse
// and sorted insert, held in a chain of cells.
// ----------------------------------------------------------------------------
// One beat is taken at a time. Insert, sorted insert into an empty list and
// errors go straight from execution to the result. Remove, search and sorted
// insert run a scan lane from the cells down to slot zero, one cell a
// cycle, before the result. Reverse moves the head into place once per
// cycle. A result waiting in the output register does not block acceptance
// of the next beat.
module positional_list_engine #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         in_mode_i,
  input  logic [8:0]         in_position_i,
  input  logic signed [31:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_status_o,
  output logic signed [31:0] out_removed_value_o,
  output logic [8:0]         out_found_position_o,
  output logic [8:0]         out_list_length_o
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_REV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [2:0]         mode_q, mode_d;
  logic [8:0]         pos_q, pos_d;
  logic signed [31:0] val_q, val_d;
  logic [CW-1:0]      count_q, count_d;
  logic [IDX_W-1:0]   step_q, step_d;
  logic [2:0]         res_status_q, res_status_d;
  logic [31:0]        res_removed_q, res_removed_d;
  logic [8:0]         res_found_q, res_found_d;
  logic               out_valid_q, out_valid_d;
  logic [2:0]         out_status_q;
  logic [31:0]        out_removed_q;
  logic [8:0]         out_found_q, out_len_q;
  logic               out_load;

  cell_cmd_t          cmd;
  match_e             mt_sel;
  logic [IDX_W-1:0]   count13, pos13, pm1, slot;
  logic               full;
  logic [31:0]        found_w;

  logic signed [31:0] cell_data [CAPACITY];
  lane_t              cell_lane [CAPACITY];

  // cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left_w, right_w;
    lane_t              lane_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
      assign lane_w  = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
      assign lane_w  = cell_lane[g+1];
    end
    ple_cell #(.INDEX(g)) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left_w),
      .right_i(right_w),
      .head_i (cell_data[0]),
      .lane_i (lane_w),
      .data_o (cell_data[g]),
      .lane_o (cell_lane[g])
    );
  end

  assign count13 = IDX_W'(count_q);
  assign pos13   = IDX_W'(pos_q);
  assign pm1     = pos13 - IDX_W'(1);
  assign full    = count13 >= IDX_W'(CAPACITY);
  assign found_w = cell_lane[0].tag + 32'd1;

  // lane match kind follows the operation
  always_comb begin
    case (mode_q)
      MODE_SEARCH: mt_sel = MT_VAL;
      MODE_SORTED: mt_sel = MT_SORT;
      default:     mt_sel = MT_IDX;
    endcase
  end

  // sorted insert slot from head compare and scan lane
  always_comb begin
    if (val_q <= cell_data[0]) slot = '0;
    else if (cell_lane[0].aux) slot = count13;
    else slot = IDX_W'(cell_lane[0].tag);
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    pos_d         = pos_q;
    val_d         = val_q;
    count_d       = count_q;
    step_d        = step_q;
    res_status_d  = res_status_q;
    res_removed_d = res_removed_q;
    res_found_d   = res_found_q;
    cmd.op        = OP_HOLD;
    cmd.mt        = mt_sel;
    cmd.idx       = '0;
    cmd.cnt       = count13;
    cmd.val       = val_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = in_mode_i;
          pos_d   = in_position_i;
          val_d   = in_value_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d  = ST_OK;
        res_removed_d = '0;
        res_found_d   = '0;
        state_d       = S_DONE;
        case (mode_q)
          MODE_INSERT: begin
            if (full) res_status_d = ST_FULL;
            else if (pos13 == '0 || pos13 > count13 + IDX_W'(1)) res_status_d = ST_BADPOS;
            else begin
              cmd.op  = OP_INS;
              cmd.idx = pm1;
              count_d = count_q + CW'(1);
            end
          end
          MODE_REMOVE: begin
            if (count_q == '0) res_status_d = ST_EMPTY;
            else if (pos13 == '0 || pos13 > count13) res_status_d = ST_BADPOS;
            else begin
              cmd.op  = OP_LOAD;
              cmd.idx = pm1;
              step_d  = count13;
              state_d = S_SCAN;
            end
          end
          MODE_SEARCH: begin
            if (count_q == '0) res_status_d = ST_NOTFOUND;
            else begin
              cmd.op  = OP_LOAD;
              step_d  = count13;
              state_d = S_SCAN;
            end
          end
          MODE_REVERSE: begin
            if (count_q == '0) res_status_d = ST_EMPTY;
            else if (count13 != IDX_W'(1)) begin
              step_d  = count13 - IDX_W'(1);
              state_d = S_REV;
            end
          end
          MODE_SORTED: begin
            if (full) res_status_d = ST_FULL;
            else if (count_q == '0) begin
              cmd.op  = OP_INS;
              cmd.idx = '0;
              count_d = count_q + CW'(1);
            end else begin
              cmd.op  = OP_LOAD;
              step_d  = count13;
              state_d = S_SCAN;
            end
          end
          default: res_status_d = ST_OK;
        endcase
      end
      S_SCAN: begin
        if (step_q != '0) begin
          cmd.op  = OP_SCAN;
          cmd.idx = pm1;
          step_d  = step_q - IDX_W'(1);
        end else begin
          state_d = S_DONE;
          case (mode_q)
            MODE_REMOVE: begin
              cmd.op        = OP_REM;
              cmd.idx       = pm1;
              res_removed_d = cell_lane[0].tag;
              count_d       = count_q - CW'(1);
            end
            MODE_SEARCH: begin
              if (cell_lane[0].hit) res_found_d = found_w[8:0];
              else res_status_d = ST_NOTFOUND;
            end
            MODE_SORTED: begin
              cmd.op  = OP_INS;
              cmd.idx = slot;
              count_d = count_q + CW'(1);
            end
            default: res_status_d = res_status_q;
          endcase
        end
      end
      S_REV: begin
        // head moves to the shrinking tail boundary
        cmd.op  = OP_ROT;
        cmd.idx = step_q;
        step_d  = step_q - IDX_W'(1);
        if (step_q == IDX_W'(1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output beat register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q        <= mode_d;
    pos_q         <= pos_d;
    val_q         <= val_d;
    step_q        <= step_d;
    res_status_q  <= res_status_d;
    res_removed_q <= res_removed_d;
    res_found_q   <= res_found_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_removed_q <= res_removed_q;
      out_found_q   <= res_found_q;
      out_len_q     <= 9'(count_q);
    end
  end

  assign in_stall_o           = (state_q != S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign out_status_o         = out_status_q;
  assign out_removed_value_o  = out_removed_q;
  assign out_found_position_o = out_found_q;
  assign out_list_length_o    = out_len_q;

  // checks
`include "positional_list_engine_macros.svh"
  `PLE_ASSERT_CLK(a_count_bound, count_q <= CW'(CAPACITY), "list count above capacity")
  `PLE_ASSERT_IMPL(a_scan_nonempty, state_q == S_SCAN, count_q != '0, "scan on empty list")
  `PLE_ASSERT_IMPL(a_err_no_removed, out_valid_o && (out_status_o != ST_OK), out_removed_value_o == '0, "removed value on failed beat")

endmodule

FILE: hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, shifts with its neighbors and carries the
// scan lane toward slot zero.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic               clk_i,
  input  ple_pkg::cell_cmd_t cmd_i,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  input  logic signed [31:0] head_i,
  input  ple_pkg::lane_t     lane_i,
  output logic signed [31:0] data_o,
  output ple_pkg::lane_t     lane_o
);
  import ple_pkg::*;

  localparam logic [IDX_W-1:0] MY = IDX_W'(INDEX);

  logic signed [31:0] data_q, data_d;
  lane_t              lane_q, lane_d;
  logic               src, aux_src, le_left;
  logic [31:0]        tag;

  // match source for the scan lane
  always_comb begin
    le_left = left_i <= cmd_i.val;
    case (cmd_i.mt)
      MT_IDX:  src = (MY == cmd_i.idx);
      MT_VAL:  src = (data_q == cmd_i.val) && (MY < cmd_i.cnt);
      MT_SORT: src = (MY != '0) && (MY < cmd_i.cnt) && le_left && (cmd_i.val <= data_q);
      default: src = 1'b0;
    endcase
    aux_src = (cmd_i.mt == MT_SORT) && (MY != '0) && (MY == cmd_i.cnt) && le_left;
    tag     = (cmd_i.mt == MT_IDX) ? data_q : 32'(INDEX);
  end

  // entry update
  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      OP_INS: begin
        if (MY == cmd_i.idx) data_d = cmd_i.val;
        else if (MY > cmd_i.idx) data_d = left_i;
      end
      OP_REM: begin
        if (MY >= cmd_i.idx) data_d = right_i;
      end
      OP_ROT: begin
        if (MY < cmd_i.idx) data_d = right_i;
        else if (MY == cmd_i.idx) data_d = head_i;
      end
      default: data_d = data_q;
    endcase
  end

  // scan lane, nearest hit to slot zero wins
  always_comb begin
    lane_d = lane_q;
    case (cmd_i.op)
      OP_LOAD: begin
        lane_d.hit = src;
        lane_d.aux = aux_src;
        lane_d.tag = tag;
      end
      OP_SCAN: begin
        lane_d.hit = src | lane_i.hit;
        lane_d.aux = aux_src | lane_i.aux;
        lane_d.tag = src ? tag : lane_i.tag;
      end
      default: lane_d = lane_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    lane_q <= lane_d;
  end

  assign data_o = data_q;
  assign lane_o = lane_q;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional list engine: a directed set of
// edge cases, then random insert/remove/search/reverse/sorted-insert beats
// with random source and sink idling, checked against a local list model.
// ----------------------------------------------------------------------------
module tb_top;
  import ple_pkg::*;

  localparam int unsigned LIST_CAP = 256;
  localparam int          RAND_BEATS = 660;
  localparam longint      CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [2:0]         mode;
    logic [8:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct {
    logic [2:0]         status;
    logic signed [31:0] removed;
    logic [8:0]         found;
    logic [8:0]         length;
  } rsp_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         in_mode_i;
  logic [8:0]         in_position_i;
  logic signed [31:0] in_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         out_status_o;
  logic signed [31:0] out_removed_value_o;
  logic [8:0]         out_found_position_o;
  logic [8:0]         out_list_length_o;

  req_t               pending_reqs[$];
  rsp_t               expected_rsps[$];
  logic signed [31:0] list_model[$];
  int                 error_count;
  int                 checked_count;
  int                 src_idle_pct;
  int                 snk_idle_pct;
  longint             cycle_count;
  bit                 stim_done;

  positional_list_engine #(.CAPACITY(LIST_CAP)) uut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // list model: applies one beat and returns the result
  function automatic rsp_t apply_list_op(req_t r);
    rsp_t o;
    int   n;
    int   slot;
    logic signed [31:0] t;
    o = '{status: ST_OK, removed: '0, found: '0, length: '0};
    n = list_model.size();
    case (r.mode)
      MODE_INSERT: begin
        if (n >= LIST_CAP) o.status = ST_FULL;
        else if (r.position < 1 || r.position > n + 1) o.status = ST_BADPOS;
        else list_model.insert(r.position - 1, r.value);
      end
      MODE_REMOVE: begin
        if (n == 0) o.status = ST_EMPTY;
        else if (r.position < 1 || r.position > n) o.status = ST_BADPOS;
        else begin
          o.removed = list_model[r.position - 1];
          list_model.delete(r.position - 1);
        end
      end
      MODE_SEARCH: begin
        for (int i = 0; i < n; i++) begin
          if (list_model[i] == r.value) begin
            o.found = i + 1;
            break;
          end
        end
        if (o.found == 0) o.status = ST_NOTFOUND;
      end
      MODE_REVERSE: begin
        if (n == 0) o.status = ST_EMPTY;
        else begin
          for (int i = 0; i < n / 2; i++) begin
            t = list_model[i];
            list_model[i] = list_model[n - 1 - i];
            list_model[n - 1 - i] = t;
          end
        end
      end
      MODE_SORTED: begin
        if (n >= LIST_CAP) o.status = ST_FULL;
        else begin
          // not above head goes first, not below tail appends
          slot = n;
          if (n == 0 || r.value <= list_model[0]) slot = 0;
          else if (r.value >= list_model[n - 1]) slot = n;
          else begin
            for (int i = 0; i + 1 < n; i++) begin
              if (r.value >= list_model[i] && r.value <= list_model[i + 1]) begin
                slot = i + 1;
                break;
              end
            end
          end
          list_model.insert(slot, r.value);
        end
      end
      default: ;
    endcase
    o.length = list_model.size();
    return o;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 15)) - 8;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] pick_known();
    if (list_model.size() > 0 && $urandom_range(0, 2) != 0)
      return list_model[$urandom_range(0, list_model.size() - 1)];
    return pick_value();
  endfunction

  // queue a beat, predicting its result on the fly
  task automatic push_beat(logic [2:0] m, logic [8:0] p, logic signed [31:0] v);
    req_t r;
    r = '{mode: m, position: p, value: v};
    pending_reqs.push_back(r);
    expected_rsps.push_back(apply_list_op(r));
  endtask

  // random beat biased to legal positions, with a fill target
  task automatic push_random(int target);
    int n;
    int k;
    logic [8:0] p;
    n = list_model.size();
    k = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 511);
    else p = $urandom_range(1, n + 1);
    if (k < 2) push_beat($urandom_range(5, 7), $urandom_range(0, 511), $urandom());
    else if (k < 8) push_beat(MODE_REVERSE, p, pick_value());
    else if (k < 25) push_beat(MODE_SEARCH, p, pick_known());
    else if (n < target) begin
      if (k < 60) push_beat(MODE_INSERT, p, pick_value());
      else push_beat(MODE_SORTED, p, pick_value());
    end else push_beat(MODE_REMOVE, p, pick_value());
  endtask

  // driver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      in_mode_i     <= '0;
      in_position_i <= '0;
      in_value_i    <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_valid_i    <= 1'b1;
        in_mode_i     <= pending_reqs[0].mode;
        in_position_i <= pending_reqs[0].position;
        in_value_i    <= pending_reqs[0].value;
        void'(pending_reqs.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // sink stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 99) < snk_idle_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result beat");
        error_count = error_count + 1;
      end else begin
        e = expected_rsps.pop_front();
        checked_count = checked_count + 1;
        if (out_status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status_o);
          error_count = error_count + 1;
        end
        if (out_removed_value_o !== e.removed) begin
          $error("removed_value: expected %0d, got %0d", e.removed, out_removed_value_o);
          error_count = error_count + 1;
        end
        if (out_found_position_o !== e.found) begin
          $error("found_position: expected %0d, got %0d", e.found, out_found_position_o);
          error_count = error_count + 1;
        end
        if (out_list_length_o !== e.length) begin
          $error("list_length: expected %0d, got %0d", e.length, out_list_length_o);
          error_count = error_count + 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int target;
    error_count   = 0;
    checked_count = 0;
    cycle_count   = 0;
    stim_done     = 1'b0;
    src_idle_pct  = 11;
    snk_idle_pct  = 45;
    rst_ni        = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty-list cases, then small-list edge cases
    push_beat(MODE_REMOVE, 9'd1, 32'sd0);
    push_beat(MODE_REVERSE, 9'd0, 32'sd0);
    push_beat(MODE_SEARCH, 9'd0, 32'sd5);
    push_beat(MODE_INSERT, 9'd0, 32'sd1);
    push_beat(MODE_INSERT, 9'd2, 32'sd1);
    push_beat(MODE_SORTED, 9'd0, 32'sd10);
    push_beat(MODE_SORTED, 9'd0, 32'sh80000000);
    push_beat(MODE_SORTED, 9'd0, 32'sh7fffffff);
    push_beat(MODE_SORTED, 9'd0, 32'sd10);
    push_beat(MODE_SORTED, 9'd0, 32'sd3);
    push_beat(MODE_INSERT, 9'd1, 32'sd77);
    push_beat(MODE_INSERT, 9'd7, -32'sd1);
    push_beat(MODE_SEARCH, 9'd0, 32'sd10);
    push_beat(MODE_SEARCH, 9'd0, 32'sd11);
    push_beat(MODE_REMOVE, 9'd0, 32'sd0);
    push_beat(MODE_REMOVE, 9'd8, 32'sd0);
    push_beat(MODE_REMOVE, 9'd7, 32'sd0);
    push_beat(MODE_REVERSE, 9'd511, 32'sd0);
    push_beat(3'd5, 9'd511, 32'sh7fffffff);
    push_beat(3'd7, 9'd0, 32'sd0);
    push_beat(MODE_REMOVE, 9'd1, 32'sd0);
    // fill to capacity, then full cases
    while (list_model.size() < LIST_CAP)
      push_beat(MODE_INSERT, list_model.size() + 1, $urandom());
    push_beat(MODE_INSERT, 9'd1, 32'sd0);
    push_beat(MODE_SORTED, 9'd0, 32'sd0);
    push_beat(MODE_REMOVE, 9'd256, 32'sd0);
    push_beat(MODE_REVERSE, 9'd0, 32'sd0);
    // drain back to empty
    while (list_model.size() > 0)
      push_beat(MODE_REMOVE, $urandom_range(1, list_model.size()), 32'sd0);

    // random phases: source idles lightly, then sink lightly, then none
    for (int ph = 0; ph < 3; ph++) begin
      wait (pending_reqs.size() == 0);
      src_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 45 : 0;
      snk_idle_pct = (ph == 0) ? 45 : (ph == 1) ? 11 : 0;
      for (int i = 0; i < RAND_BEATS / 3; i++) begin
        // mostly short lists, sometimes near capacity
        if (i % 100 == 0)
          target = ($urandom_range(0, 3) == 0) ? LIST_CAP + 2 : $urandom_range(2, 24);
        push_random(target);
      end
    end
    stim_done = 1'b1;

    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
    repeat (LIST_CAP + 20) @(posedge clk_i);
    $display("tb_top: %0d results checked over directed edge cases and %0d random beats",
             checked_count, RAND_BEATS);
    $display("tb_top: covered full, empty, bad position, misses and sorted placement");
    if (error_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
